// ===== rtl/kvt_pkg.sv =====
// Package for the key/value list tokenizer.
// Holds word types, kind and state codes, character constants and sizes.
// No dependencies.
package kvt_pkg;

  // Default longest key or value plus one.
  localparam int KVT_MAX_LEN = 32;

  // Wanted-key register holds this many characters.
  localparam int WANT_CHARS = 8;
  localparam int WANT_LEN_W = 4;

  // Configuration port sizes and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_TEXT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_LEN      = 2'd2;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    KIND_KEY       = 2'd0,
    KIND_VALUE     = 2'd1,
    KIND_PAIR_END  = 2'd2,
    KIND_TEXT_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SECOND = 2'd1,
    ST_BURST  = 2'd2
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    kind_t      kind;
    logic       last;
  } out_word_t;

endpackage

// ===== rtl/key_value_list_tokenizer.sv =====
// Key/value list tokenizer: character words in; key, value, pair-end and text-done words out.
// The first result of a character reaches out_word in the cycle after it is accepted;
// key words come from the key RAM, so they pass its read register before the output register.
// Throughput: one character per cycle while the sequencer is idle and the output slot is free;
// a second result, or the key read-out from the key RAM at '=', holds off the next character.
// Reset (synchronous, rst_n low) clears control and parse state, not key RAM or data words.
module key_value_list_tokenizer
  import kvt_pkg::*;
#(
  parameter int MAX_LEN = KVT_MAX_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_LEN);
  localparam int KAW = (MAX_LEN > 2) ? $clog2(MAX_LEN - 1) : 1;
  localparam int MW  = (CW > WANT_LEN_W) ? CW : WANT_LEN_W;
  localparam logic [CW-1:0] CNT_TOP = CW'(MAX_LEN - 1);

  // Configuration registers.
  logic                  filter_en_r;
  logic [CFG_DATA_W-1:0] want_text_r;
  logic [WANT_LEN_W-1:0] want_len_r;

  // Parse state.
  phase_t       phase_r, phase_nxt;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic          kept_r, kept_nxt;
  logic [CW-1:0] value_count_r, value_count_nxt;
  logic          slash_r, slash_nxt;
  logic [7:0]    pfx_r [WANT_CHARS];

  // Sequencer state.
  state_t         state_r, state_nxt;
  out_word_t      pend_r;
  logic [KAW-1:0] rd_idx_r;

  // Decoded results of the offered character.
  logic       accept;
  logic       term, is_comma, is_equal, is_slash;
  logic       r0_v, r1_v, burst_go, key_store;
  out_word_t  r0, r1;
  logic       key_match;
  logic [WANT_LEN_W-1:0] want_eff;
  logic [MW-1:0] key_ext;

  // Memory and output register wiring.
  logic           ram_we, ram_re;
  logic [KAW-1:0] ram_raddr;
  logic [7:0]     ram_rdata;
  logic           slot_free, load, burst_last;
  out_word_t      load_word;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      want_text_r <= '0;
      want_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLE: filter_en_r <= cfg_data[0];
        CFG_WANT_TEXT:     want_text_r <= cfg_data;
        CFG_WANT_LEN:      want_len_r  <= cfg_data[WANT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Wanted-key match against the first characters held in flops.
  assign key_ext  = MW'(key_count_r);
  assign want_eff = (want_len_r > WANT_LEN_W'(WANT_CHARS)) ? WANT_LEN_W'(WANT_CHARS)
                                                           : want_len_r;
  always_comb begin
    key_match = (key_ext == MW'(want_eff));
    for (int i = 0; i < WANT_CHARS; i++) begin
      if ((WANT_LEN_W'(i) < want_eff) && (pfx_r[i] != want_text_r[8*i +: 8])) begin
        key_match = 1'b0;
      end
    end
  end

  // Character decode: results and next parse state.
  assign term     = in_word.text_end || (in_word.ch == CH_NUL);
  assign is_comma = (in_word.ch == CH_COMMA);
  assign is_equal = (in_word.ch == CH_EQUAL);
  assign is_slash = (in_word.ch == CH_SLASH);

  always_comb begin
    logic vc_room, slash_out, char_out;
    vc_room         = (value_count_r < CNT_TOP);
    slash_out       = 1'b0;
    char_out        = 1'b0;
    r0_v            = 1'b0;
    r1_v            = 1'b0;
    r0              = '{out_char: CH_NUL, kind: KIND_TEXT_DONE, last: 1'b1};
    r1              = '{out_char: CH_NUL, kind: KIND_TEXT_DONE, last: 1'b1};
    burst_go        = 1'b0;
    key_store       = 1'b0;
    phase_nxt       = phase_r;
    key_count_nxt   = key_count_r;
    kept_nxt        = kept_r;
    value_count_nxt = value_count_r;
    slash_nxt       = slash_r;
    if (term) begin
      // Close an open kept value, then report end of text.
      r0_v = 1'b1;
      if ((phase_r == PH_VALUE) && kept_r) begin
        r0   = '{out_char: CH_NUL, kind: KIND_PAIR_END, last: 1'b0};
        r1_v = 1'b1;
      end
      phase_nxt       = PH_SKIP;
      key_count_nxt   = '0;
      kept_nxt        = 1'b0;
      value_count_nxt = '0;
      slash_nxt       = 1'b0;
    end else if (phase_r == PH_SKIP || phase_r == PH_KEY) begin
      if (is_equal) begin
        kept_nxt        = !filter_en_r || key_match;
        burst_go        = kept_nxt && (key_count_r != '0);
        phase_nxt       = PH_VALUE;
        value_count_nxt = '0;
        slash_nxt       = 1'b0;
      end else if (!(phase_r == PH_SKIP && is_comma)) begin
        key_store = (key_count_r < CNT_TOP);
        if (key_store) begin
          key_count_nxt = key_count_r + CW'(1);
        end
        phase_nxt = PH_KEY;
      end
    end else if (phase_r == PH_VALUE) begin
      if (is_comma) begin
        r0_v            = kept_r;
        r0              = '{out_char: CH_NUL, kind: KIND_PAIR_END, last: 1'b1};
        phase_nxt       = PH_SKIP;
        key_count_nxt   = '0;
        kept_nxt        = 1'b0;
        value_count_nxt = '0;
        slash_nxt       = 1'b0;
      end else begin
        // A held slash goes out once another value character follows it.
        slash_out = slash_r && kept_r;
        char_out  = vc_room && !is_slash && kept_r;
        slash_nxt = vc_room && is_slash;
        if (vc_room) begin
          value_count_nxt = value_count_r + CW'(1);
        end
        if (slash_out) begin
          r0_v = 1'b1;
          r0   = '{out_char: CH_SLASH, kind: KIND_VALUE, last: !char_out};
          r1_v = char_out;
          r1   = '{out_char: in_word.ch, kind: KIND_VALUE, last: 1'b1};
        end else begin
          r0_v = char_out;
          r0   = '{out_char: in_word.ch, kind: KIND_VALUE, last: 1'b1};
        end
      end
    end else begin
      // Unused phase code: back to the start of a pair.
      phase_nxt       = PH_SKIP;
      key_count_nxt   = '0;
      kept_nxt        = 1'b0;
      value_count_nxt = '0;
      slash_nxt       = 1'b0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SKIP;
      key_count_r   <= '0;
      kept_r        <= 1'b0;
      value_count_r <= '0;
      slash_r       <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      key_count_r   <= key_count_nxt;
      kept_r        <= kept_nxt;
      value_count_r <= value_count_nxt;
      slash_r       <= slash_nxt;
    end
  end

  // Copy of the first key characters for the wanted-key compare.
  always_ff @(posedge clk) begin
    if (accept && key_store && (key_ext < MW'(WANT_CHARS))) begin
      pfx_r[key_ext[2:0]] <= in_word.ch;
    end
  end

  // Key store.
  assign ram_we = accept && key_store;

  kvt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN - 1)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_count_r[KAW-1:0]),
    .wdata (in_word.ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign burst_last = (CW'(rd_idx_r) == (key_count_r - CW'(1)));

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && r1_v) begin
          state_nxt = ST_SECOND;
        end else if (accept && burst_go) begin
          state_nxt = ST_BURST;
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BURST: begin
        if (slot_free && burst_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input handshake, output load and key reads.
  always_comb begin
    in_ready  = 1'b0;
    load      = 1'b0;
    load_word = r0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        load     = accept && r0_v;
        ram_re   = accept && burst_go;
      end
      ST_SECOND: begin
        load      = slot_free;
        load_word = pend_r;
      end
      ST_BURST: begin
        load      = slot_free;
        load_word = '{out_char: ram_rdata, kind: KIND_KEY, last: burst_last};
        ram_re    = slot_free && !burst_last;
        ram_raddr = rd_idx_r + KAW'(1);
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Second result of a character, and the key read index.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (accept) begin
      rd_idx_r <= '0;
    end else if (state_r == ST_BURST && slot_free) begin
      rd_idx_r <= rd_idx_r + KAW'(1);
    end
  end

  kvt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_word (load_word),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/kvt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/kvt_out_reg.sv =====
// Output register for result words of the tokenizer.
// Depends on kvt_pkg for the result word type.
module kvt_out_reg
  import kvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t load_word,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      valid_r;
  out_word_t word_r;

  // The slot can take a word when empty or when its word leaves this cycle.
  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      word_r <= load_word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/kvt_checker.sv =====
// Port-level checks for the key/value list tokenizer, bound to the top level.
// Depends on kvt_pkg for word types and kind codes.
module kvt_checker
  import kvt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // No character is taken while a result word is stuck.
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // End of text is always the last result of its character.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == KIND_TEXT_DONE) |-> out_word.last)
    else $error("text done word without last");

  // Pair end and text done carry no character.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_word.kind == KIND_PAIR_END) || (out_word.kind == KIND_TEXT_DONE))
    |-> (out_word.out_char == CH_NUL))
    else $error("marker word with a character");

endmodule

bind key_value_list_tokenizer kvt_checker u_kvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
